// ===== design/stepseq_pkg.sv =====
package stepseq_pkg;

    // Width of the step position counter.
    localparam int POSITION_BITS = 12;
    // Width of the saturating elapsed tick counter.
    localparam int INTERVAL_BITS = 16;

    // Fixed field and register widths.
    localparam int SPR_BITS      = 13;
    localparam int IVL_BITS      = 16;
    localparam int PENDING_BITS  = 16;
    localparam int POS_OUT_BITS  = 12;
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    // Derived widths.
    localparam int REV_BITS     = POSITION_BITS + 1;
    localparam int REV_CMP_BITS = (SPR_BITS > REV_BITS) ? SPR_BITS : REV_BITS;
    localparam int CMP_BITS     = (INTERVAL_BITS > IVL_BITS) ? INTERVAL_BITS : IVL_BITS;
    localparam int POS_EXT_BITS = (POSITION_BITS > POS_OUT_BITS) ? POSITION_BITS : POS_OUT_BITS;

    // Item kinds.
    typedef enum logic {
        CMD_MOVE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Drive modes; code 3 steps with wave timing and leaves the coils alone.
    typedef enum logic [1:0] {
        MODE_WAVE = 2'd0,
        MODE_FULL = 2'd1,
        MODE_HALF = 2'd2
    } t_drive_mode;

    // Configuration register indexes.
    typedef enum logic {
        REG_STEPS_PER_REV = 1'b0,
        REG_STEP_INTERVAL = 1'b1
    } t_reg_index;

    // Register values after reset.
    localparam logic [SPR_BITS-1:0] SPR_RESET = SPR_BITS'(200);
    localparam logic [IVL_BITS-1:0] IVL_RESET = IVL_BITS'(10);

    // Coil patterns, pin4 in bit 3 down to pin1 in bit 0.
    localparam logic [3:0] WAVE_PATTERN [4] = '{4'hB, 4'hC, 4'hA, 4'h4};
    localparam logic [3:0] HALF_PATTERN [8] =
        '{4'h3, 4'hF, 4'hC, 4'hE, 4'h2, 4'h6, 4'h4, 4'h7};
    // Full step touches only pin4 and pin1.
    localparam logic [3:0] FULL_PATTERN [4] = '{4'h0, 4'h1, 4'h9, 4'h8};
    localparam logic [3:0] FULL_HOLD_MASK   = 4'h6;

    // Input word.
    typedef struct packed {
        logic               cmd;
        logic signed [15:0] steps_to_move;
        logic [1:0]         drive_mode;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic                    coil1;
        logic                    coil2;
        logic                    coil3;
        logic                    coil4;
        logic                    busy_res;
        logic [POS_OUT_BITS-1:0] position;
    } t_out_word;

endpackage

// ===== design/stepper_step_sequencer.sv =====
// A result word is registered into the output register, or into the skid entry while the output is held.
// Throughput: one input word per cycle while the skid is empty; all state updates in a single registered pass.
// A two-entry output buffer (output register plus skid) keeps input flowing under stall.
// Reset (synchronous, active low) clears position, direction, pending steps, mode,
// elapsed ticks, coils and the output buffer; steps_per_rev returns to 200, interval to 10.
module stepper_step_sequencer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  stepseq_pkg::t_in_word                   i_in_word,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output stepseq_pkg::t_out_word                  o_out_word,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [stepseq_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [stepseq_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [stepseq_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                    pready
);
    import stepseq_pkg::*;

    // Configuration registers.
    logic [SPR_BITS-1:0] r_steps_per_rev;
    logic [IVL_BITS-1:0] r_step_interval;

    // Sequencer state.
    logic [POSITION_BITS-1:0] r_position, n_position;
    logic                     r_forward, n_forward;
    logic [PENDING_BITS-1:0]  r_pending, n_pending;
    logic [1:0]               r_mode, n_mode;
    logic [INTERVAL_BITS-1:0] r_elapsed, n_elapsed;
    logic [3:0]               r_coils, n_coils;

    // Output buffer.
    logic      r_out_valid, r_skid_valid;
    t_out_word r_out_word, r_skid_word;

    logic      in_accept, out_pop, cfg_write;
    t_reg_index reg_index;
    t_out_word result;

    // Step decision signals.
    logic [INTERVAL_BITS-1:0] elapsed_inc;
    logic [IVL_BITS-1:0]      interval_eff;
    logic                     step_now;
    logic [REV_CMP_BITS-1:0]  spr_ext, rev_cap, rev_clamped;
    logic [REV_BITS-1:0]      rev_size, rev_last, pos_inc;
    logic [POSITION_BITS-1:0] step_pos;
    logic [POS_EXT_BITS-1:0]  pos_ext;
    logic [PENDING_BITS-1:0]  move_count;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_pop   = r_out_valid && !i_out_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = t_reg_index'(paddr[2]);

    // APB port: always ready, reads return the stored register.
    assign pready = 1'b1;
    always_comb begin
        unique case (reg_index)
            REG_STEPS_PER_REV: prdata = APB_DATA_BITS'(r_steps_per_rev);
            REG_STEP_INTERVAL: prdata = APB_DATA_BITS'(r_step_interval);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_rev <= SPR_RESET;
            r_step_interval <= IVL_RESET;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_STEPS_PER_REV: r_steps_per_rev <= pwdata[SPR_BITS-1:0];
                REG_STEP_INTERVAL: r_step_interval <= pwdata[IVL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Revolution size, clamped to 1 .. 2^POSITION_BITS.
    assign spr_ext = REV_CMP_BITS'(r_steps_per_rev);
    assign rev_cap = REV_CMP_BITS'(1) << POSITION_BITS;
    always_comb begin
        priority if (spr_ext == '0) begin
            rev_clamped = REV_CMP_BITS'(1);
        end else if (spr_ext > rev_cap) begin
            rev_clamped = rev_cap;
        end else begin
            rev_clamped = spr_ext;
        end
    end
    assign rev_size = rev_clamped[REV_BITS-1:0];
    assign rev_last = rev_size - REV_BITS'(1);

    // Next position for one step in the current direction.
    assign pos_inc = REV_BITS'(r_position) + REV_BITS'(1);
    always_comb begin
        if (r_forward) begin
            step_pos = (pos_inc >= rev_size) ? '0 : pos_inc[POSITION_BITS-1:0];
        end else begin
            step_pos = (r_position == '0) ? rev_last[POSITION_BITS-1:0]
                                          : r_position - POSITION_BITS'(1);
        end
    end

    // Saturating tick count and the step condition; half mode halves the interval.
    assign elapsed_inc  = (&r_elapsed) ? r_elapsed : r_elapsed + INTERVAL_BITS'(1);
    assign interval_eff = (r_mode == MODE_HALF) ? (r_step_interval >> 1) : r_step_interval;
    assign step_now     = (r_pending != '0)
                       && (CMP_BITS'(elapsed_inc) >= CMP_BITS'(interval_eff));

    // Magnitude of the move count; the most negative count gives 32768.
    assign move_count = i_in_word.steps_to_move[15] ? PENDING_BITS'(-i_in_word.steps_to_move)
                                                     : PENDING_BITS'(i_in_word.steps_to_move);

    // Next state for the accepted word.
    always_comb begin
        n_position = r_position;
        n_forward  = r_forward;
        n_pending  = r_pending;
        n_mode     = r_mode;
        n_elapsed  = r_elapsed;
        n_coils    = r_coils;
        unique case (t_cmd'(i_in_word.cmd))
            CMD_MOVE: begin
                n_pending = move_count;
                if (i_in_word.steps_to_move[15]) begin
                    n_forward = 1'b0;
                end else if (i_in_word.steps_to_move != '0) begin
                    n_forward = 1'b1;
                end
                n_mode = i_in_word.drive_mode;
                if (i_in_word.drive_mode == MODE_FULL) begin
                    n_coils = r_coils | FULL_HOLD_MASK;
                end
            end
            CMD_TICK: begin
                n_elapsed = elapsed_inc;
                if (step_now) begin
                    n_position = step_pos;
                    n_pending  = r_pending - PENDING_BITS'(1);
                    n_elapsed  = '0;
                    unique case (r_mode)
                        MODE_WAVE: n_coils = WAVE_PATTERN[step_pos[1:0]];
                        MODE_HALF: n_coils = HALF_PATTERN[step_pos[2:0]];
                        MODE_FULL: n_coils = (r_coils & FULL_HOLD_MASK)
                                           | FULL_PATTERN[step_pos[1:0]];
                        default:   n_coils = r_coils;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_forward  <= 1'b0;
            r_pending  <= '0;
            r_mode     <= MODE_WAVE;
            r_elapsed  <= '0;
            r_coils    <= '0;
        end else if (in_accept) begin
            r_position <= n_position;
            r_forward  <= n_forward;
            r_pending  <= n_pending;
            r_mode     <= n_mode;
            r_elapsed  <= n_elapsed;
            r_coils    <= n_coils;
        end
    end

    // Result word built from the updated state.
    assign pos_ext = POS_EXT_BITS'(n_position);
    always_comb begin
        result.coil1    = n_coils[0];
        result.coil2    = n_coils[1];
        result.coil3    = n_coils[2];
        result.coil4    = n_coils[3];
        result.busy_res = (n_pending != '0);
        result.position = pos_ext[POS_OUT_BITS-1:0];
    end

    // Output register with a skid entry; input stalls only when the skid is full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            if (r_skid_valid) begin
                r_out_word <= r_skid_word;
            end else if (in_accept) begin
                r_out_word <= result;
            end
        end else if (in_accept) begin
            r_skid_word <= result;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A filled skid entry always sits behind a valid output word.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output register is empty");

    // A step on a tick restarts the elapsed count.
    a_step_clears_elapsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.cmd == CMD_TICK && step_now) |=> (r_elapsed == '0))
        else $error("elapsed count not cleared after a step");

    // Ticks never add to the pending step count.
    a_tick_no_pending_growth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.cmd == CMD_TICK) |=> (r_pending <= $past(r_pending)))
        else $error("pending steps grew on a tick");

    // The position stays inside the revolution after a forward step.
    a_forward_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.cmd == CMD_TICK && step_now && r_forward)
            |=> (REV_BITS'(r_position) < $past(rev_size)))
        else $error("forward step left the revolution range");

endmodule

// ===== sim/tb_stepper_step_sequencer.sv =====
`timescale 1ns / 100ps

module tb_stepper_step_sequencer;
    import stepseq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REV_CAP     = 4096;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 150;

    // Drive mode code that the package leaves unnamed.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Coil tables, pin4 in bit 3 down to pin1 in bit 0.
    localparam logic [3:0] WAVE_COILS [4] = '{4'hB, 4'hC, 4'hA, 4'h4};
    localparam logic [3:0] HALF_COILS [8] = '{4'h3, 4'hF, 4'hC, 4'hE, 4'h2, 4'h6, 4'h4, 4'h7};
    localparam logic [3:0] FULL_COILS [4] = '{4'h0, 4'h1, 4'h9, 4'h8};
    // Full step holds pins 2 and 3 high and leaves them alone on each step.
    localparam logic [3:0] FULL_HELD      = 4'h6;

    localparam t_out_word NO_WANT = '0;

    // One line of the directed script: a register write or an input word.
    typedef struct {
        bit          is_cfg;
        t_reg_index  idx;
        logic [31:0] value;
        t_in_word    word;
        bit          typed;
        t_out_word   want;
    } t_script_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    t_in_word                 i_in_word = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    t_out_word                o_out_word;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Shadow of the registers and of the motor state.
    logic [12:0] cfg_rev = 13'd200;
    logic [15:0] cfg_interval = 16'd10;
    logic [11:0] mot_pos = '0;
    logic        mot_fwd = 1'b0;
    logic [16:0] mot_pending = '0;
    logic [1:0]  mot_mode = MODE_WAVE;
    logic [15:0] mot_elapsed = '0;
    logic [3:0]  mot_coils = '0;

    t_out_word   drive_due [$];
    t_script_row script [$];
    int          errors = 0;
    int          cycle_count = 0;
    int          rx_hold = 0;
    bit          calm = 1'b0;

    stepper_step_sequencer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #10 i_clk = ~i_clk;

    // Advance the motor state by one word and return the drive word it produces.
    function automatic t_out_word advance_motor(input t_in_word w);
        int          count;
        int          rev;
        int          nxt;
        logic [15:0] limit;
        t_out_word   r;
        if (w.cmd == CMD_MOVE) begin
            count = $signed(w.steps_to_move);
            if (count < 0) begin
                mot_pending = 17'(-count);
                mot_fwd = 1'b0;
            end else begin
                mot_pending = 17'(count);
                if (count != 0) begin
                    mot_fwd = 1'b1;
                end
            end
            mot_mode = w.drive_mode;
            if (w.drive_mode == MODE_FULL) begin
                mot_coils = mot_coils | FULL_HELD;
            end
        end else begin
            if (mot_elapsed != 16'hFFFF) begin
                mot_elapsed = mot_elapsed + 16'd1;
            end
            limit = (mot_mode == MODE_HALF) ? (cfg_interval >> 1) : cfg_interval;
            if (mot_pending != 0 && mot_elapsed >= limit) begin
                // The revolution size is clamped to 1 .. 2^POSITION_BITS.
                rev = (cfg_rev == 0) ? 1 : ((cfg_rev > REV_CAP) ? REV_CAP : int'(cfg_rev));
                if (mot_fwd) begin
                    nxt = int'(mot_pos) + 1;
                    if (nxt >= rev) begin
                        nxt = 0;
                    end
                end else begin
                    nxt = (mot_pos == 0) ? rev - 1 : int'(mot_pos) - 1;
                end
                mot_pos = 12'(nxt);
                mot_pending = mot_pending - 17'd1;
                mot_elapsed = '0;
                case (mot_mode)
                    MODE_HALF: mot_coils = HALF_COILS[mot_pos[2:0]];
                    MODE_WAVE: mot_coils = WAVE_COILS[mot_pos[1:0]];
                    MODE_FULL: mot_coils = (mot_coils & FULL_HELD) | FULL_COILS[mot_pos[1:0]];
                    default: ;
                endcase
            end
        end
        r.coil1 = mot_coils[0];
        r.coil2 = mot_coils[1];
        r.coil3 = mot_coils[2];
        r.coil4 = mot_coils[3];
        r.busy_res = (mot_pending != 0);
        r.position = mot_pos;
        return r;
    endfunction

    function automatic t_in_word random_word(input t_cmd c);
        t_in_word w;
        int       mag;
        w.cmd = c;
        w.steps_to_move = 16'($urandom);
        w.drive_mode = 2'($urandom_range(0, 3));
        if (c == CMD_MOVE) begin
            mag = $urandom_range(0, 12);
            case ($urandom_range(0, 9))
                0: ;
                1: begin
                    case ($urandom_range(0, 3))
                        0: w.steps_to_move = 16'sh8000;
                        1: w.steps_to_move = 16'sh7FFF;
                        2: w.steps_to_move = -16'sd1;
                        default: w.steps_to_move = 16'sd1;
                    endcase
                end
                default: w.steps_to_move = $urandom_range(0, 1) ? -16'(mag) : 16'(mag);
            endcase
            w.drive_mode = ($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Compare one drive word with the oldest one predicted.
    task automatic check_drive(input t_out_word got);
        t_out_word want;
        if (drive_due.size() == 0) begin
            errors++;
            $display("%0t unexpected word: expected none, actual %h", $time, got);
        end else begin
            want = drive_due.pop_front();
            if (got.coil1 !== want.coil1) report_mismatch("coil1", want.coil1, got.coil1);
            if (got.coil2 !== want.coil2) report_mismatch("coil2", want.coil2, got.coil2);
            if (got.coil3 !== want.coil3) report_mismatch("coil3", want.coil3, got.coil3);
            if (got.coil4 !== want.coil4) report_mismatch("coil4", want.coil4, got.coil4);
            if (got.busy_res !== want.busy_res) begin
                report_mismatch("busy_res", want.busy_res, got.busy_res);
            end
            if (got.position !== want.position) begin
                report_mismatch("position", want.position, got.position);
            end
        end
    endtask

    // Present one word, wait until it is taken, then record its prediction.
    task automatic feed_word(input t_in_word w, input bit typed, input t_out_word want);
        int        gap;
        t_out_word pred;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        pred = advance_motor(w);
        drive_due.push_back(typed ? want : pred);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (drive_due.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Write a register over the bus and read it back.
    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] held;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        pwrite <= 1'b1;
        psel <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_STEPS_PER_REV) begin
            cfg_rev = value[12:0];
        end else begin
            cfg_interval = value[15:0];
        end
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        held = (idx == REG_STEPS_PER_REV) ? 32'(cfg_rev) : 32'(cfg_interval);
        if (readback !== held) begin
            report_mismatch("register readback", held, readback);
        end
        // Leave the bus idle before the next transfer.
        @(posedge i_clk);
    endtask

    task automatic add_word(input t_cmd c, input int count, input logic [1:0] mode,
                            input bit typed, input t_out_word want);
        t_script_row row;
        row.is_cfg = 1'b0;
        row.idx = REG_STEPS_PER_REV;
        row.value = '0;
        row.word.cmd = c;
        row.word.steps_to_move = 16'(count);
        row.word.drive_mode = mode;
        row.typed = typed;
        row.want = want;
        script.push_back(row);
    endtask

    task automatic add_cfg(input t_reg_index idx, input logic [31:0] value);
        t_script_row row;
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.value = value;
        row.word = '0;
        row.typed = 1'b0;
        row.want = NO_WANT;
        script.push_back(row);
    endtask

    // Receiving side: take words, then hold off for a random number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                check_drive(o_out_word);
                rx_hold = calm ? 0 : $urandom_range(0, 5);
            end else if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
            end
            i_out_stall <= (rx_hold > 0);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int  sent;
        int  ticks;
        int  rev_pick;
        int  ivl_pick;
        int  rev_val;
        int  ivl_val;
        bit  paused;

        // Directed script: reset values, count extremes, every mode and the corner cases.
        add_word(CMD_TICK, -1, MODE_UNUSED, 1'b1, NO_WANT);
        add_word(CMD_MOVE, 0, MODE_WAVE, 1'b1, NO_WANT);
        add_word(CMD_MOVE, -32768, MODE_FULL, 1'b1,
                 t_out_word'{coil1: 1'b0, coil2: 1'b1, coil3: 1'b1, coil4: 1'b0,
                             busy_res: 1'b1, position: '0});
        add_cfg(REG_STEP_INTERVAL, 0);
        // Reverse from position zero wraps to the top of the revolution.
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        // A revolution size of zero behaves as one.
        add_cfg(REG_STEPS_PER_REV, 0);
        add_word(CMD_MOVE, 32767, MODE_HALF, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        // An oversized revolution is clamped; the unused mode leaves the coils alone.
        add_cfg(REG_STEPS_PER_REV, 8191);
        add_word(CMD_MOVE, -1, MODE_UNUSED, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        // Position above a reduced revolution size.
        add_cfg(REG_STEPS_PER_REV, 10);
        add_word(CMD_MOVE, -1, MODE_WAVE, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        add_word(CMD_MOVE, 1, MODE_FULL, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        add_cfg(REG_STEP_INTERVAL, 65535);
        add_cfg(REG_STEPS_PER_REV, 4096);
        add_word(CMD_MOVE, 3, MODE_HALF, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);
        add_word(CMD_TICK, 0, MODE_WAVE, 1'b0, NO_WANT);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                settle();
                write_reg(script[k].idx, script[k].value);
            end else begin
                feed_word(script[k].word, script[k].typed, script[k].want);
            end
        end

        // Random phases: a move followed by a run of ticks, under a new setting each time.
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            calm = (ph % 4 == 3);
            rev_pick = (ph < 6) ? ph : $urandom_range(0, 5);
            ivl_pick = (ph < 6) ? (ph + 3) % 6 : $urandom_range(0, 5);
            case (rev_pick)
                0: rev_val = 0;
                1: rev_val = 1;
                2: rev_val = REV_CAP;
                3: rev_val = $urandom_range(REV_CAP + 1, 8191);
                4: rev_val = 200;
                default: rev_val = $urandom_range(2, 16);
            endcase
            case (ivl_pick)
                0: ivl_val = 0;
                1: ivl_val = $urandom_range(1, 4);
                2: ivl_val = 65535;
                3: ivl_val = $urandom_range(1, 6);
                4: ivl_val = $urandom_range(5, 20);
                default: ivl_val = 1;
            endcase
            write_reg(REG_STEPS_PER_REV, rev_val);
            write_reg(REG_STEP_INTERVAL, ivl_val);
            sent = 0;
            paused = 1'b0;
            while (sent < PHASE_WORDS) begin
                feed_word(random_word(CMD_MOVE), 1'b0, NO_WANT);
                sent++;
                ticks = $urandom_range(1, 30);
                repeat (ticks) begin
                    feed_word(random_word(CMD_TICK), 1'b0, NO_WANT);
                    sent++;
                end
                // Once, let the pipeline run dry in the middle of a move.
                if (ph == 1 && !paused && sent > PHASE_WORDS / 2) begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
